>>> rtl/core/posa_pkg.sv
// Shared types for the per-operator statistics accumulator.
// Holds the entry layout, item kinds, controller states and control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package posa_pkg;

    // Reset value of the operators-in-use register
    localparam logic [4:0] OPS_RESET = 5'd16;

    // Input item kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    // One statistics entry as held in the store
    typedef struct packed {
        logic [31:0] cnt;
        logic [63:0] data;
        logic [63:0] lat;
    } entry_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_READ,
        ST_LOAD,
        ST_SEND,
        ST_CLEAR
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_event;   // record item accepted this cycle
        logic rd_dump;      // read store at dump index
        logic load_out;     // capture read data into output register
        logic idx_clear;    // restart dump index
        logic idx_step;     // advance dump index
        logic clear_all;    // clear every entry
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pipe_busy;    // record items still in flight
        logic cnt_zero;     // no operators in use
        logic idx_last;     // dump index is the final entry
        logic out_taken;    // output item accepted this cycle
    } dp_status_t;

endpackage

>>> rtl/core/posa_ctrl.sv
// Controller for the statistics accumulator: input handshake and dump sequence.
// Depends on posa_pkg.
`timescale 1ns / 1ps

module posa_ctrl
    import posa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       kind,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_DUMP)
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.take_event = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                // let in-flight updates land before reading the store
                if (!status.pipe_busy)
                begin
                    if (status.cnt_zero)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.rd_dump = 1'b1;
                        state_next  = ST_LOAD;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_dump = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_taken)
                begin
                    if (status.idx_last)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.idx_step = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_all = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/posa_dpath.sv
// Datapath for the statistics accumulator: update pipeline, entry store,
// dump index and output register. Depends on posa_pkg.
`timescale 1ns / 1ps

module posa_dpath
    import posa_pkg::*;
#(
    parameter int MAX_OPERATORS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic [3:0]  operator_index,
    input  logic [31:0] tuple_count,
    input  logic [15:0] tuple_bytes,
    input  logic [47:0] insert_time,
    input  logic [47:0] finish_time,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [3:0]  entry_index,
    output logic [31:0] event_count,
    output logic [63:0] data_total,
    output logic [63:0] latency_total,
    output logic        last_of_run,
    input  ctl_cmd_t    cmd,
    output dp_status_t  status
);

    localparam int AW    = (MAX_OPERATORS > 1) ? $clog2(MAX_OPERATORS) : 1;
    localparam int NW    = $clog2(MAX_OPERATORS + 1);
    localparam int CW    = (NW > 5) ? NW : 5;

    // Configuration and effective count
    logic [4:0]    ops_reg;
    logic [CW-1:0] n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ops_reg <= OPS_RESET;
        end
        else if (cfg_we)
        begin
            ops_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (CW'(ops_reg) > CW'(MAX_OPERATORS))
        begin
            n_eff = CW'(MAX_OPERATORS);
        end
        else
        begin
            n_eff = CW'(ops_reg);
        end
    end

    // Stage 1: captured record item, dropped if out of range
    logic          s1_valid_reg;
    logic [3:0]    s1_op_reg;
    logic [31:0]   s1_count_reg;
    logic [15:0]   s1_bytes_reg;
    logic [47:0]   s1_ins_reg;
    logic [47:0]   s1_fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.take_event && (CW'(operator_index) < n_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_event)
        begin
            s1_op_reg    <= operator_index;
            s1_count_reg <= tuple_count;
            s1_bytes_reg <= tuple_bytes;
            s1_ins_reg   <= insert_time;
            s1_fin_reg   <= finish_time;
        end
    end

    // Stage 1 math: product and time difference (sign-extended into stage 2)
    logic [47:0] s1_prod;
    logic [48:0] s1_diff;

    assign s1_prod = 48'(s1_count_reg) * 48'(s1_bytes_reg);
    assign s1_diff = {1'b0, s1_fin_reg} - {1'b0, s1_ins_reg};

    // Entry store with per-entry valid bits
    entry_t             mem [MAX_OPERATORS];
    logic [MAX_OPERATORS-1:0] valid_reg;
    logic [CW-1:0]      idx_reg;
    logic [AW-1:0]      rd_addr;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    assign rd_addr = cmd.rd_dump ? AW'(idx_reg) : AW'(s1_op_reg);

    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // Stage 2: read-modify-write
    logic          s2_valid_reg;
    logic [3:0]    s2_op_reg;
    logic [47:0]   s2_prod_reg;
    logic [63:0]   s2_diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg   <= s1_op_reg;
        s2_prod_reg <= s1_prod;
        s2_diff_reg <= {{15{s1_diff[48]}}, s1_diff};
    end

    // Forward the entry written last cycle; its read went out before the write
    logic        wr_valid_reg;
    logic [3:0]  wr_op_reg;
    entry_t      wr_data_reg;
    entry_t      base;
    entry_t      upd;

    always_comb
    begin
        if (wr_valid_reg && (wr_op_reg == s2_op_reg))
        begin
            base = wr_data_reg;
        end
        else if (rd_valid_reg)
        begin
            base = rd_data_reg;
        end
        else
        begin
            base = '0;
        end
        upd.cnt  = base.cnt + 32'd1;
        upd.data = base.data + 64'(s2_prod_reg);
        upd.lat  = base.lat + s2_diff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_op_reg   <= s2_op_reg;
        wr_data_reg <= upd;
        if (s2_valid_reg)
        begin
            mem[AW'(s2_op_reg)] <= upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            valid_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            valid_reg[AW'(s2_op_reg)] <= 1'b1;
        end
    end

    // Dump index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_step)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    // Output register
    logic out_valid_reg;
    logic [3:0]  out_idx_reg;
    entry_t      out_data_reg;
    logic        out_last_reg;
    logic        idx_last;

    assign idx_last = (CW'(idx_reg + CW'(1)) == n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_idx_reg  <= idx_reg[3:0];
            out_data_reg <= rd_valid_reg ? rd_data_reg : '0;
            out_last_reg <= idx_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_index   = out_idx_reg;
    assign event_count   = out_data_reg.cnt;
    assign data_total    = out_data_reg.data;
    assign latency_total = out_data_reg.lat;
    assign last_of_run   = out_last_reg;

    // Status back to controller
    assign status.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign status.cnt_zero  = (n_eff == '0);
    assign status.idx_last  = idx_last;
    assign status.out_taken = out_valid_reg & out_ready;

endmodule

>>> rtl/core/per_operator_stats_accumulator.sv
// Record items: one per cycle while no dump is running; each is captured,
// then multiplied/subtracted, then added and written with forwarding.
// Dump item: waits for in-flight records, then per entry a store read, an
// output load and a handoff (held until out_ready), then clears all entries.
// Reset: all entries read as zero (valid bits cleared), operators_in_use = 16.
`timescale 1ns / 1ps

module per_operator_stats_accumulator
    import posa_pkg::*;
#(
    parameter int MAX_OPERATORS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [3:0]         operator_index,
    input  logic [31:0]        tuple_count,
    input  logic [15:0]        tuple_bytes,
    input  logic [47:0]        insert_time,
    input  logic [47:0]        finish_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         entry_index,
    output logic [31:0]        event_count,
    output logic [63:0]        data_total,
    output logic signed [63:0] latency_total,
    output logic               last_of_run
);

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic [63:0] lat_raw;

    // Sequencer
    posa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store and arithmetic
    posa_dpath #(
        .MAX_OPERATORS (MAX_OPERATORS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .operator_index (operator_index),
        .tuple_count    (tuple_count),
        .tuple_bytes    (tuple_bytes),
        .insert_time    (insert_time),
        .finish_time    (finish_time),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .entry_index    (entry_index),
        .event_count    (event_count),
        .data_total     (data_total),
        .latency_total  (lat_raw),
        .last_of_run    (last_of_run),
        .cmd            (cmd),
        .status         (status)
    );

    assign latency_total = $signed(lat_raw);

endmodule
